[rtl/ltwsd_pkg.sv]
// shared types, codes and constants of the load trend worker spawn decider
package ltwsd_pkg;

	localparam int HIST_DEPTH_DEF = 16;

	localparam int REQ_W    = 2;
	localparam int AMOUNT_W = 16;
	localparam int WORKER_W = 8;
	localparam int CODE_W   = 3;
	localparam int LOAD_W   = 32;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam int MIN_HIST_W = 5;
	localparam int MIN_LOAD_W = 16;
	localparam int MAX_WK_W   = 8;
	localparam int COOL_W     = 5;

	localparam logic [MIN_HIST_W-1:0] MIN_HIST_RST = MIN_HIST_W'(8);
	localparam logic [MIN_LOAD_W-1:0] MIN_LOAD_RST = MIN_LOAD_W'(15);
	localparam logic [MAX_WK_W-1:0]   MAX_WK_RST   = MAX_WK_W'(128);
	localparam logic [COOL_W-1:0]     COOL_RST     = COOL_W'(16);

	typedef enum logic [REQ_W-1:0] {
		REQ_ADD    = 2'd0,
		REQ_RETIRE = 2'd1,
		REQ_CHECK  = 2'd2,
		REQ_RSVD   = 2'd3
	} req_type_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MIN_HISTORY = 2'd0,
		CFG_MIN_LOAD    = 2'd1,
		CFG_MAX_WORKERS = 2'd2,
		CFG_COOLDOWN    = 2'd3
	} cfg_idx_t;

	typedef enum logic [CODE_W-1:0] {
		DEC_GRANT      = 3'd0,
		DEC_COOLDOWN   = 3'd1,
		DEC_LIMIT      = 3'd2,
		DEC_SHORT_HIST = 3'd3,
		DEC_ABOVE_BEST = 3'd4,
		DEC_LOW_LOAD   = 3'd5,
		DEC_FALLING    = 3'd6,
		DEC_NO_CHECK   = 3'd7
	} decision_t;

	typedef enum logic [1:0] {
		ST_IDLE   = 2'd0,
		ST_SCAN   = 2'd1,
		ST_DRAIN  = 2'd2,
		ST_FINISH = 2'd3
	} ctrl_state_t;

	typedef struct packed {
		logic take;
		logic scan_step;
		logic finish;
		logic out_load;
	} ltwsd_cmd_t;

	typedef struct packed {
		logic need_scan;
		logic issue_last;
	} ltwsd_status_t;

endpackage

[rtl/ltwsd_ifs.sv]
// valid/ready channel interfaces for requests, decisions and configuration writes
interface ltwsd_req_if import ltwsd_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [REQ_W-1:0]    req_type;
	logic [AMOUNT_W-1:0] amount;
	logic [WORKER_W-1:0] worker_count;

	modport source (output valid, req_type, amount, worker_count, input ready);
	modport sink   (input valid, req_type, amount, worker_count, output ready);
endinterface

interface ltwsd_rsp_if import ltwsd_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              grant_worker;
	logic [CODE_W-1:0] decision_code;

	modport source (output valid, grant_worker, decision_code, input ready);
	modport sink   (input valid, grant_worker, decision_code, output ready);
endinterface

interface ltwsd_cfg_if import ltwsd_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

[rtl/ltwsd_ctrl.sv]
// controller state machine: handshakes and sequencing of the history scan
module ltwsd_ctrl import ltwsd_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	input  ltwsd_status_t st,
	output ltwsd_cmd_t    cmd
);

	ctrl_state_t state_q, state_d;
	logic        out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				// output register is free or drains in this cycle
				req_ready = !out_valid_q || rsp_ready;
				if (req_valid && req_ready) begin
					cmd.take = 1'b1;
					if (st.need_scan) begin
						state_d = ST_SCAN;
					end else begin
						cmd.out_load = 1'b1;
					end
				end
			end
			ST_SCAN: begin
				cmd.scan_step = 1'b1;
				if (st.issue_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_FINISH;
			end
			ST_FINISH: begin
				cmd.finish   = 1'b1;
				cmd.out_load = 1'b1;
				state_d      = ST_IDLE;
			end
		endcase
	end

	assign rsp_valid = out_valid_q;

`ifndef SYNTHESIS
	a_ready_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req_ready |-> (state_q == ST_IDLE))
		else $error("request ready outside idle");

	a_valid_from_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(cmd.out_load))
		else $error("result valid without a load");

	a_scan_exit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |=> (state_q == ST_SCAN || state_q == ST_DRAIN))
		else $error("scan left to a wrong state");

	a_finish_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FINISH) |-> !out_valid_q)
		else $error("result register busy at scan finish");
`endif

endmodule

[rtl/ltwsd_dp.sv]
// datapath: counters, configuration, load history memory and scan accumulators
module ltwsd_dp import ltwsd_pkg::*; #(
	parameter int HISTORY_DEPTH = HIST_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [REQ_W-1:0]      req_type,
	input  logic [AMOUNT_W-1:0]   amount,
	input  logic [WORKER_W-1:0]   worker_count,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  ltwsd_cmd_t            cmd,
	output ltwsd_status_t         st,
	output logic                  grant_worker,
	output logic [CODE_W-1:0]     decision_code
);

	localparam int PW   = $clog2(HISTORY_DEPTH);
	localparam int FW   = $clog2(HISTORY_DEPTH + 1);
	localparam int SUMW = LOAD_W + PW;
	localparam int CMPW = (FW > MIN_HIST_W) ? FW : MIN_HIST_W;

	// configuration registers
	logic [MIN_HIST_W-1:0] min_hist_q;
	logic [MIN_LOAD_W-1:0] min_load_q;
	logic [MAX_WK_W-1:0]   max_wk_q;
	logic [COOL_W-1:0]     cool_cfg_q;

	logic [LOAD_W-1:0]   pending_q;
	logic [LOAD_W-1:0]   completed_q;
	logic [LOAD_W-1:0]   best_q;
	logic [WORKER_W-1:0] best_cnt_q;
	logic [COOL_W-1:0]   cool_q;
	logic [PW-1:0]       head_q;
	logic [FW-1:0]       fill_q;

	logic [LOAD_W-1:0] hist_mem [HISTORY_DEPTH];

	logic [FW-1:0]     idx_q;
	logic              rd_vld_s1;
	logic [FW-1:0]     rd_idx_s1;
	logic [LOAD_W-1:0] rd_data_s1;
	logic [SUMW-1:0]   sum_old_q;
	logic [SUMW-1:0]   sum_new_q;
	logic              low_q;

	logic              grant_q;
	decision_t         code_q;

	req_type_t         rtype;
	logic [LOAD_W:0]   pend_add;
	logic [LOAD_W:0]   comp_add;
	logic              hist_full;
	logic [FW-1:0]     fill_next;
	logic [FW:0]       wr_sum;
	logic [PW-1:0]     wr_addr;
	logic [PW-1:0]     head_inc;
	logic [FW:0]       rd_sum;
	logic [PW-1:0]     rd_addr;
	logic              best_gt;
	logic [WORKER_W-1:0] best_cnt_next;
	decision_t         early_code;
	logic              early_hit;
	decision_t         final_code;
	decision_t         code_sel;
	logic [FW-1:0]     lo_end;
	logic [FW-1:0]     hi_start;
	logic              is_take_check;

	always_comb begin
		rtype     = req_type_t'(req_type);
		pend_add  = {1'b0, pending_q} + (LOAD_W+1)'(amount);
		comp_add  = {1'b0, completed_q} + (LOAD_W+1)'(amount);
		hist_full = (fill_q == FW'(HISTORY_DEPTH));
		fill_next = hist_full ? fill_q : fill_q + FW'(1);
		// head + fill wraps once at most; when full this lands on head
		wr_sum    = (FW+1)'(head_q) + (FW+1)'(fill_q);
		wr_addr   = (wr_sum >= (FW+1)'(HISTORY_DEPTH)) ?
			PW'(wr_sum - (FW+1)'(HISTORY_DEPTH)) : PW'(wr_sum);
		head_inc  = (head_q == PW'(HISTORY_DEPTH - 1)) ? '0 : head_q + PW'(1);
		rd_sum    = (FW+1)'(head_q) + (FW+1)'(idx_q);
		rd_addr   = (rd_sum >= (FW+1)'(HISTORY_DEPTH)) ?
			PW'(rd_sum - (FW+1)'(HISTORY_DEPTH)) : PW'(rd_sum);
		best_gt       = completed_q > best_q;
		best_cnt_next = best_gt ? worker_count : best_cnt_q;
		lo_end    = fill_q >> 1;
		hi_start  = FW'(((FW+1)'(fill_q) + (FW+1)'(1)) >> 1);
		is_take_check = cmd.take && (rtype == REQ_CHECK);

		early_hit  = 1'b1;
		early_code = DEC_NO_CHECK;
		if (rtype == REQ_CHECK) begin
			priority if (cool_q != '0) begin
				early_code = DEC_COOLDOWN;
			end else if (worker_count > max_wk_q) begin
				early_code = DEC_LIMIT;
			end else if (CMPW'(fill_next) < CMPW'(min_hist_q)) begin
				early_code = DEC_SHORT_HIST;
			end else if (best_cnt_next < worker_count) begin
				early_code = DEC_ABOVE_BEST;
			end else begin
				early_hit  = 1'b0;
				early_code = DEC_GRANT;
			end
		end

		priority if (low_q) begin
			final_code = DEC_LOW_LOAD;
		end else if (sum_old_q > sum_new_q) begin
			final_code = DEC_FALLING;
		end else begin
			final_code = DEC_GRANT;
		end

		code_sel = cmd.finish ? final_code : early_code;
	end

	assign st.need_scan  = (rtype == REQ_CHECK) && !early_hit;
	assign st.issue_last = (idx_q == fill_q - FW'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_hist_q <= MIN_HIST_RST;
			min_load_q <= MIN_LOAD_RST;
			max_wk_q   <= MAX_WK_RST;
			cool_cfg_q <= COOL_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_MIN_HISTORY: min_hist_q <= cfg_data[MIN_HIST_W-1:0];
				CFG_MIN_LOAD:    min_load_q <= cfg_data[MIN_LOAD_W-1:0];
				CFG_MAX_WORKERS: max_wk_q   <= cfg_data[MAX_WK_W-1:0];
				CFG_COOLDOWN:    cool_cfg_q <= cfg_data[COOL_W-1:0];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q   <= '0;
			completed_q <= '0;
			best_q      <= '0;
			best_cnt_q  <= '0;
			cool_q      <= '0;
			head_q      <= '0;
			fill_q      <= '0;
		end else if (cmd.take) begin
			unique case (rtype)
				REQ_ADD: begin
					pending_q <= pend_add[LOAD_W] ? '1 : pend_add[LOAD_W-1:0];
				end
				REQ_RETIRE: begin
					pending_q   <= (pending_q > LOAD_W'(amount)) ?
						pending_q - LOAD_W'(amount) : '0;
					completed_q <= comp_add[LOAD_W] ? '1 : comp_add[LOAD_W-1:0];
				end
				REQ_CHECK: begin
					fill_q <= fill_next;
					if (hist_full) begin
						head_q <= head_inc;
					end
					if (best_gt) begin
						best_q     <= completed_q;
						best_cnt_q <= worker_count;
					end
					completed_q <= '0;
					if (cool_q != '0) begin
						cool_q <= cool_q - COOL_W'(1);
					end
				end
				REQ_RSVD: begin
				end
			endcase
		end else if (cmd.finish && final_code == DEC_GRANT) begin
			cool_q <= cool_cfg_q;
		end
	end

	// history memory: one write at a check, one registered read per scan cycle
	always_ff @(posedge clk) begin
		if (is_take_check) begin
			hist_mem[wr_addr] <= pending_q;
		end
		if (cmd.scan_step) begin
			rd_data_s1 <= hist_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1 <= 1'b0;
			idx_q     <= '0;
			sum_old_q <= '0;
			sum_new_q <= '0;
			low_q     <= 1'b0;
		end else begin
			rd_vld_s1 <= cmd.scan_step;
			priority if (is_take_check) begin
				idx_q     <= '0;
				sum_old_q <= '0;
				sum_new_q <= '0;
				low_q     <= 1'b0;
			end else begin
				if (cmd.scan_step) begin
					idx_q <= idx_q + FW'(1);
				end
				// middle entry of an odd length falls in neither half
				if (rd_vld_s1) begin
					if (rd_idx_s1 < lo_end) begin
						sum_old_q <= sum_old_q + SUMW'(rd_data_s1);
					end else if (rd_idx_s1 >= hi_start) begin
						sum_new_q <= sum_new_q + SUMW'(rd_data_s1);
						if (rd_data_s1 < LOAD_W'(min_load_q)) begin
							low_q <= 1'b1;
						end
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= idx_q;
		if (cmd.out_load) begin
			grant_q <= (code_sel == DEC_GRANT);
			code_q  <= code_sel;
		end
	end

	assign grant_worker  = grant_q;
	assign decision_code = code_q;

`ifndef SYNTHESIS
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FW'(HISTORY_DEPTH))
		else $error("history fill beyond depth");

	a_scan_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan_step |-> (idx_q < fill_q))
		else $error("scan index outside filled history");
`endif

endmodule

[rtl/load_trend_worker_spawn_decider.sv]
// top level of the load trend worker spawn decider
// Usage: requests enter on req (req_type, amount, worker_count) with valid/ready;
// one decision per request leaves on rsp (grant_worker, decision_code).
// Add-load and retire requests update the saturating pending-load and
// completed-work counters and answer with the not-a-check code; they can
// be accepted every cycle while rsp keeps up.
// A check pushes the pending load into the history memory and settles
// cooldown, worker limit, history length and best count in its accept cycle.
// If those pass, the history is read back one entry per cycle through the
// single memory read port over the fill entries (fill is the number of
// history entries, at most HISTORY_DEPTH), then the decision is loaded.
// Configuration writes on cfg are always accepted and are meant for idle time.
// Results sit in an output register; a stalled receiver holds the decision
// there and req is accepted again once that register drains.
// Reset clears all counters, the history fill and the configuration to its
// defaults; history contents are not cleared, so no clearing pass is needed.
module load_trend_worker_spawn_decider import ltwsd_pkg::*; #(
	parameter int HISTORY_DEPTH = HIST_DEPTH_DEF
) (
	input logic        clk,
	input logic        arst_n,
	ltwsd_req_if.sink  req,
	ltwsd_rsp_if.source rsp,
	ltwsd_cfg_if.sink  cfg
);

	ltwsd_cmd_t    cmd;
	ltwsd_status_t st;

	assign cfg.ready = 1'b1;

	ltwsd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.st        (st),
		.cmd       (cmd)
	);

	ltwsd_dp #(
		.HISTORY_DEPTH (HISTORY_DEPTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.req_type      (req.req_type),
		.amount        (req.amount),
		.worker_count  (req.worker_count),
		.cfg_we        (cfg.valid && cfg.ready),
		.cfg_index     (cfg.index),
		.cfg_data      (cfg.data),
		.cmd           (cmd),
		.st            (st),
		.grant_worker  (rsp.grant_worker),
		.decision_code (rsp.decision_code)
	);

endmodule
